// ===== rtl/serial_reply_frame_checker_macros.svh =====
// Assertion macros shared by the reply frame checker modules.
`ifndef SERIAL_REPLY_FRAME_CHECKER_MACROS_SVH
`define SERIAL_REPLY_FRAME_CHECKER_MACROS_SVH

// Check a property on a given clock, off while the given reset is low.
`define SRFC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on the block clock and reset.
`define SRFC_ASSERT(lbl, prop, msg) \
  `SRFC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/srfc_pkg.sv =====
// Types, codes and constants of the reply frame checker.
`default_nettype none

package srfc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;

  localparam logic [CFG_IDX_W-1:0] CFG_EXP_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_COMMAND = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PREAMBLE = 3'd1,
    ST_FC_ERR   = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_COMMAND  = 3'd5,
    ST_CHECKSUM = 3'd6
  } status_e;

  typedef enum logic [6:0] {
    PH_SYNC1   = 7'b0000001,
    PH_SYNC2   = 7'b0000010,
    PH_DIR     = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_CMD     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    status_e           status;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/srfc_channels.sv =====
// Handshake channels of the reply frame checker: bytes in, results out, register writes.
`default_nettype none

interface srfc_rx_if import srfc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfc_res_if import srfc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [2:0]        status;
  logic              last;

  modport source (output valid, output kind, output payload_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input last, output ready);
endinterface

interface srfc_cfg_if import srfc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/srfc_front.sv =====
// Front end: takes received bytes, tracks the frame phase and classifies results.
`default_nettype none

`include "serial_reply_frame_checker_macros.svh"

module srfc_front import srfc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  srfc_rx_if.sink                rx_i,
  input  wire logic [BYTE_W-1:0] exp_len_i,
  input  wire logic [BYTE_W-1:0] exp_cmd_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output res_t                   push_data_o
);

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [BYTE_W-1:0] left_q, left_d;
  logic              accept;
  logic              fin;
  logic              pay;
  status_e           code;
  logic [BYTE_W-1:0] b;

  assign rx_i.ready = !q_full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  always_comb begin
    phase_d = phase_q;
    xor_d   = xor_q;
    left_d  = left_q;
    fin     = 1'b0;
    pay     = 1'b0;
    code    = ST_OK;
    case (phase_q)
      PH_SYNC2: begin
        if (b != CH_M) begin
          fin  = 1'b1;
          code = ST_PREAMBLE;
        end else begin
          phase_d = PH_DIR;
        end
      end
      PH_DIR: begin
        if (b == CH_GT) begin
          phase_d = PH_LEN;
        end else begin
          fin  = 1'b1;
          code = (b == CH_BANG) ? ST_FC_ERR : ST_UNKNOWN;
        end
      end
      PH_LEN: begin
        if (b != exp_len_i) begin
          fin  = 1'b1;
          code = ST_LENGTH;
        end else begin
          left_d  = b;
          xor_d   = b;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        if (b != exp_cmd_i) begin
          fin  = 1'b1;
          code = ST_COMMAND;
        end else begin
          xor_d   = xor_q ^ b;
          phase_d = (left_q != '0) ? PH_PAYLOAD : PH_CHECK;
        end
      end
      PH_PAYLOAD: begin
        pay    = 1'b1;
        xor_d  = xor_q ^ b;
        left_d = left_q - 1'b1;
        if (left_q == BYTE_W'(1)) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        fin  = 1'b1;
        code = (b == xor_q) ? ST_OK : ST_CHECKSUM;
      end
      default: begin
        // Hunt for the opening preamble byte.
        if (b != CH_DOLLAR) begin
          fin  = 1'b1;
          code = ST_PREAMBLE;
        end else begin
          xor_d   = '0;
          left_d  = '0;
          phase_d = PH_SYNC2;
        end
      end
    endcase
    if (fin) begin
      phase_d = PH_SYNC1;
      xor_d   = '0;
      left_d  = '0;
    end
  end

  always_comb begin
    push_o = accept && (fin || pay);
    if (pay) begin
      push_data_o.kind         = KIND_PAYLOAD;
      push_data_o.payload_byte = b;
      push_data_o.status       = ST_OK;
      push_data_o.last         = 1'b0;
    end else begin
      push_data_o.kind         = KIND_STATUS;
      push_data_o.payload_byte = '0;
      push_data_o.status       = code;
      push_data_o.last         = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      xor_q   <= '0;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      left_q  <= left_d;
    end
  end

  `SRFC_ASSERT(a_status_ends_frame, push_o && push_data_o.kind == KIND_STATUS |=> phase_q == PH_SYNC1, "status item did not return the front end to preamble hunt")
  `SRFC_ASSERT(a_payload_in_payload_phase, push_o && push_data_o.kind == KIND_PAYLOAD |-> phase_q == PH_PAYLOAD && left_q != '0, "payload item outside the payload phase")

endmodule

`default_nettype wire

// ===== rtl/srfc_fifo.sv =====
// Short result queue between the front end and the output stage.
`default_nettype none

`include "serial_reply_frame_checker_macros.svh"

module srfc_fifo import srfc_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output res_t      head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `SRFC_ASSERT(a_no_push_when_full, push_i |-> !full_o, "push into a full result queue")
  `SRFC_ASSERT(a_no_pop_when_empty, pop_i |-> valid_o, "pop from an empty result queue")

endmodule

`default_nettype wire

// ===== rtl/srfc_back.sv =====
// Output stage: moves queued results into the result register and hands them out.
`default_nettype none

`include "serial_reply_frame_checker_macros.svh"

module srfc_back import srfc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire res_t q_data_i,
  output logic      q_pop_o,
  srfc_res_if.source res_o
);

  logic out_valid_q;
  res_t out_q;
  logic load;

  // Refill the result register when it is empty or being taken.
  assign load    = q_valid_i && (!out_valid_q || res_o.ready);
  assign q_pop_o = load;

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.payload_byte = out_q.payload_byte;
  assign res_o.status       = out_q.status;
  assign res_o.last         = out_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= q_data_i;
    end
  end

  `SRFC_ASSERT(a_idle_output_refills, q_valid_i && !out_valid_q |=> out_valid_q, "queued item not moved into an empty result register")

endmodule

`default_nettype wire

// ===== rtl/serial_reply_frame_checker.sv =====
// Reply frame checker top level: register file, front end, result queue and output stage.
// A result enters the result queue at the edge that accepts its byte, then moves into the result register.
// Throughput: one byte per cycle; the front end stalls only while the result queue
// (QueueDepth entries) is full because the output side holds back.
// Reset: phase goes to preamble hunt, checksum and count clear, expected length and
// command clear to zero, queue and result register empty. No clearing pass.
`default_nettype none

module serial_reply_frame_checker import srfc_pkg::*; #(
  parameter int unsigned QueueDepth = FIFO_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srfc_cfg_if.sink   cfg_i,
  srfc_rx_if.sink    rx_i,
  srfc_res_if.source res_o
);

  logic [BYTE_W-1:0] exp_len_q;
  logic [BYTE_W-1:0] exp_cmd_q;
  logic              q_full;
  logic              push;
  res_t              push_data;
  logic              q_valid;
  res_t              q_head;
  logic              q_pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      exp_cmd_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_EXP_LENGTH:  exp_len_q <= cfg_i.data;
        CFG_EXP_COMMAND: exp_cmd_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  srfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .exp_len_i   (exp_len_q),
    .exp_cmd_i   (exp_cmd_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  srfc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  srfc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_head),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
